/* hdl/lams_pkg.sv */
package lams_pkg;

  localparam int SENSOR_NUM = 6;
  localparam int READING_W  = 10;
  localparam int PULSE_W    = 9;
  localparam int DIST_W     = 8;
  localparam int COUNT_W    = 8;
  localparam int ECHO_W     = 20;
  localparam int OP_W       = 2;
  localparam int MOTOR_W    = 3;
  localparam int CLASS_W    = 2;
  localparam int PHASE_W    = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 10;

  // distance = (width / 2) / 29, so the limit test is width < 58 * (limit + 1)
  localparam int ECHO_DIV   = 58;
  localparam int ECHO_LIM_W = 15;

  localparam int IN_DATA_W  = SENSOR_NUM * READING_W + ECHO_W + 3 * COUNT_W;
  localparam int OUT_DATA_W = MOTOR_W + 1 + CLASS_W + OP_W;

  // event codes, also used for the awaiting field
  localparam logic [OP_W-1:0] OP_LINE   = 2'd0;
  localparam logic [OP_W-1:0] OP_PULSE  = 2'd1;
  localparam logic [OP_W-1:0] OP_ECHO   = 2'd2;
  localparam logic [OP_W-1:0] OP_COLOUR = 2'd3;

  localparam logic [PHASE_W-1:0] PH_LINE   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_BACK   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_TURN   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ECHO   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_COLOUR = 3'd4;

  localparam logic [MOTOR_W-1:0] M_STOP  = 3'd0;
  localparam logic [MOTOR_W-1:0] M_FWD   = 3'd1;
  localparam logic [MOTOR_W-1:0] M_REV   = 3'd2;
  localparam logic [MOTOR_W-1:0] M_RIGHT = 3'd3;
  localparam logic [MOTOR_W-1:0] M_LEFT  = 3'd4;

  localparam logic [CLASS_W-1:0] CLR_NONE  = 2'd0;
  localparam logic [CLASS_W-1:0] CLR_RED   = 2'd1;
  localparam logic [CLASS_W-1:0] CLR_BLUE  = 2'd2;
  localparam logic [CLASS_W-1:0] CLR_GREEN = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_DARK_THR   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SHORT_BACK = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TURN       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDE_TURN  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LONG_TURN  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OBST_CM    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_GREEN_MIN  = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_RED_MAX    = 3'd7;

  localparam logic [READING_W-1:0] RST_DARK_THR   = 10'd650;
  localparam logic [PULSE_W-1:0]   RST_SHORT_BACK = 9'd20;
  localparam logic [PULSE_W-1:0]   RST_TURN       = 9'd84;
  localparam logic [PULSE_W-1:0]   RST_WIDE_TURN  = 9'd126;
  localparam logic [PULSE_W-1:0]   RST_LONG_TURN  = 9'd294;
  localparam logic [DIST_W-1:0]    RST_OBST_CM    = 8'd3;
  localparam logic [COUNT_W-1:0]   RST_GREEN_MIN  = 8'd100;
  localparam logic [COUNT_W-1:0]   RST_RED_MAX    = 8'd80;

  // dark masks, bit 0 is the leftmost sensor
  localparam logic [SENSOR_NUM-1:0] MASK_ALL    = 6'b111111;
  localparam logic [SENSOR_NUM-1:0] DARK_EDGE_1 = 6'b100001;
  localparam logic [SENSOR_NUM-1:0] DARK_EDGE_2 = 6'b110011;
  localparam logic [SENSOR_NUM-1:0] DARK_L1     = 6'b000001;
  localparam logic [SENSOR_NUM-1:0] DARK_L2     = 6'b000011;
  localparam logic [SENSOR_NUM-1:0] DARK_L3     = 6'b000111;
  localparam logic [SENSOR_NUM-1:0] DARK_L4     = 6'b001111;
  localparam logic [SENSOR_NUM-1:0] DARK_L5     = 6'b011111;

  // maneuver chosen by a line frame
  localparam int MAN_W = 2;
  localparam logic [MAN_W-1:0] MAN_DEFAULT  = 2'd0;
  localparam logic [MAN_W-1:0] MAN_ALL_DARK = 2'd1;
  localparam logic [MAN_W-1:0] MAN_EDGES    = 2'd2;
  localparam logic [MAN_W-1:0] MAN_LEFT     = 2'd3;

  typedef struct packed {
    logic             all_light;
    logic [MAN_W-1:0] kind;
  } frame_dec_t;

endpackage

/* hdl/lams_frame_class.sv */
module lams_frame_class (
  input  logic [lams_pkg::SENSOR_NUM-1:0][lams_pkg::READING_W-1:0] readings,
  input  logic [lams_pkg::READING_W-1:0]                           threshold,
  output lams_pkg::frame_dec_t                                     dec
);
  import lams_pkg::*;

  logic [SENSOR_NUM-1:0] dark;
  logic [SENSOR_NUM-1:0] light;
  logic                  clean;

  always_comb begin
    for (int i = 0; i < SENSOR_NUM; i++) begin
      dark[i]  = readings[i] > threshold;
      light[i] = readings[i] < threshold;
    end
  end

  // a reading equal to the threshold spoils the frame
  assign clean = (dark | light) == MASK_ALL;

  always_comb begin
    dec.all_light = light == MASK_ALL;
    priority if (clean && dark == MASK_ALL) begin
      dec.kind = MAN_ALL_DARK;
    end else if (clean && (dark == DARK_EDGE_1 || dark == DARK_EDGE_2)) begin
      dec.kind = MAN_EDGES;
    end else if (clean && (dark == DARK_L1 || dark == DARK_L2 || dark == DARK_L3 ||
                           dark == DARK_L4 || dark == DARK_L5)) begin
      dec.kind = MAN_LEFT;
    end else begin
      dec.kind = MAN_DEFAULT;
    end
  end

endmodule

/* hdl/line_avoid_maneuver_sequencer_top.sv */
// Channel  | Direction | tdata (lowest bit up)                        | tuser        | tlast
// ---------+-----------+----------------------------------------------+--------------+-----------
// in_      | slave     | sensor_a..f (10 each), echo_width_us (20),   | opcode       | -
//          |           | red_count, green_count, blue_count (8 each)  |              |
// out_     | master    | motor_cmd (3), servo_raised, colour_class    | colour_valid | cycle_done
//          |           | (2), awaiting (2)                            |              |
// cfg_     | write     | cfg_addr selects the register, cfg_wdata     | -            | -
//
// One item per clock while out_tready is high: each item is held in an input register,
// decided by shallow logic against the sequencer state, and its result is registered in
// the output register when the input stage advances.
// Reset (rst_n low at a clock edge) restores every configuration register to its default,
// sets the sequencer to wait for a line frame with the motor stopped, and empties both stages.
// With out_tready low the result holds, one more item waits in the input register, and
// in_tready then drops until the result is taken.
module line_avoid_maneuver_sequencer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // write port
  input  logic                            cfg_wr_en,
  input  logic [lams_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lams_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // event items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // sensor_a..f, echo_width_us, red_count, green_count, blue_count
  input  logic [lams_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [lams_pkg::OP_W-1:0]       in_tuser,
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // motor_cmd, servo_raised, colour_class, awaiting
  output logic [lams_pkg::OUT_DATA_W-1:0] out_tdata,
  // colour_valid
  output logic                            out_tuser,
  // cycle_done
  output logic                            out_tlast
);
  import lams_pkg::*;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [PULSE_W-1:0] pulse_cnt;
    logic [PULSE_W-1:0] target;
    logic               turn_left;
    logic [PULSE_W-1:0] turn_target;
    logic               after_obst;
    logic [MOTOR_W-1:0] motor;
    logic               servo;
  } seq_st_t;

  // configuration registers
  logic [READING_W-1:0] dark_thr_r;
  logic [PULSE_W-1:0]   short_back_r;
  logic [PULSE_W-1:0]   turn_r;
  logic [PULSE_W-1:0]   wide_turn_r;
  logic [PULSE_W-1:0]   long_turn_r;
  logic [DIST_W-1:0]    obst_cm_r;
  logic [COUNT_W-1:0]   green_min_r;
  logic [COUNT_W-1:0]   red_max_r;

  // input stage
  logic                 in_valid_r;
  logic [IN_DATA_W-1:0] in_data_r;
  logic [OP_W-1:0]      in_op_r;
  logic                 advance;

  // sequencer state
  seq_st_t st_r;
  seq_st_t st_nxt;

  // output stage
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_cvalid_r;
  logic                  out_done_r;

  // unpacked fields of the held item
  logic [SENSOR_NUM-1:0][READING_W-1:0] readings;
  logic [ECHO_W-1:0]                    echo_w;
  logic [COUNT_W-1:0]                   red_c;
  logic [COUNT_W-1:0]                   green_c;
  logic [COUNT_W-1:0]                   blue_c;
  frame_dec_t                           frame_dec;

  // per-item decision values
  logic [DIST_W:0]       obst_p1;
  logic [ECHO_LIM_W-1:0] echo_lim;
  logic                  obstacle;
  logic [CLASS_W-1:0]    colour;
  logic [PULSE_W-1:0]    pulse_inc;
  logic [CLASS_W-1:0]    class_nxt;
  logic                  cvalid_nxt;
  logic                  done_nxt;
  logic [OP_W-1:0]       await_nxt;

  // maneuver launch
  logic                  do_man;
  logic [PULSE_W-1:0]    man_back;
  logic                  man_left;
  logic [PULSE_W-1:0]    man_turn;
  logic                  man_obst;
  logic                  start_turn;
  logic                  end_turn;
  logic                  finish;

  // ---------------------------------------------------------------------------
  // Handshake: take a new item whenever the input stage is empty or moves on
  // ---------------------------------------------------------------------------
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
      in_op_r   <= in_tuser;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_thr_r   <= RST_DARK_THR;
      short_back_r <= RST_SHORT_BACK;
      turn_r       <= RST_TURN;
      wide_turn_r  <= RST_WIDE_TURN;
      long_turn_r  <= RST_LONG_TURN;
      obst_cm_r    <= RST_OBST_CM;
      green_min_r  <= RST_GREEN_MIN;
      red_max_r    <= RST_RED_MAX;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_DARK_THR:   dark_thr_r   <= cfg_wdata[READING_W-1:0];
        REG_SHORT_BACK: short_back_r <= cfg_wdata[PULSE_W-1:0];
        REG_TURN:       turn_r       <= cfg_wdata[PULSE_W-1:0];
        REG_WIDE_TURN:  wide_turn_r  <= cfg_wdata[PULSE_W-1:0];
        REG_LONG_TURN:  long_turn_r  <= cfg_wdata[PULSE_W-1:0];
        REG_OBST_CM:    obst_cm_r    <= cfg_wdata[DIST_W-1:0];
        REG_GREEN_MIN:  green_min_r  <= cfg_wdata[COUNT_W-1:0];
        REG_RED_MAX:    red_max_r    <= cfg_wdata[COUNT_W-1:0];
        default:        dark_thr_r   <= dark_thr_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Field unpacking and line frame classification
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < SENSOR_NUM; i++) begin : g_read
    assign readings[i] = in_data_r[i*READING_W +: READING_W];
  end

  assign echo_w  = in_data_r[SENSOR_NUM*READING_W +: ECHO_W];
  assign red_c   = in_data_r[SENSOR_NUM*READING_W + ECHO_W +: COUNT_W];
  assign green_c = in_data_r[SENSOR_NUM*READING_W + ECHO_W + COUNT_W +: COUNT_W];
  assign blue_c  = in_data_r[SENSOR_NUM*READING_W + ECHO_W + 2*COUNT_W +: COUNT_W];

  lams_frame_class u_frame_class (
    .readings  (readings),
    .threshold (dark_thr_r),
    .dec       (frame_dec)
  );

  // Obstacle when width/58 <= limit, i.e. width < 58 * (limit + 1): no divider needed
  assign obst_p1  = {1'b0, obst_cm_r} + (DIST_W+1)'(1);
  assign echo_lim = ECHO_LIM_W'(ECHO_LIM_W'(obst_p1) * ECHO_LIM_W'(ECHO_DIV));
  assign obstacle = echo_w < ECHO_W'(echo_lim);

  // Colour class: red first, then blue, then green; when no strict test holds the class is none
  always_comb begin
    priority if (red_c < blue_c && green_c > green_min_r && red_c < red_max_r) begin
      colour = CLR_RED;
    end else if (blue_c < red_c && blue_c < green_c) begin
      colour = CLR_BLUE;
    end else if (green_c < red_c && green_c < blue_c) begin
      colour = CLR_GREEN;
    end else begin
      colour = CLR_NONE;
    end
  end

  assign pulse_inc = st_r.pulse_cnt + PULSE_W'(1);

  // ---------------------------------------------------------------------------
  // Next state. Steps run in order within one item: a maneuver may start its
  // turn at once, and a turn may end at once, when a pulse target is zero.
  // ---------------------------------------------------------------------------
  always_comb begin
    st_nxt     = st_r;
    class_nxt  = CLR_NONE;
    cvalid_nxt = 1'b0;
    do_man     = 1'b0;
    man_back   = short_back_r;
    man_left   = 1'b0;
    man_turn   = turn_r;
    man_obst   = 1'b0;
    start_turn = 1'b0;
    end_turn   = 1'b0;
    finish     = 1'b0;

    if (in_op_r == OP_LINE && st_r.phase == PH_LINE) begin
      st_nxt.motor = M_FWD;
      st_nxt.servo = 1'b0;
      if (frame_dec.all_light) begin
        st_nxt.pulse_cnt = '0;
        st_nxt.phase     = PH_ECHO;
      end else begin
        do_man = 1'b1;
        unique case (frame_dec.kind)
          MAN_ALL_DARK: begin
            man_turn = wide_turn_r;
          end
          MAN_EDGES: begin
            man_back = turn_r;
            man_turn = long_turn_r;
          end
          MAN_LEFT: begin
            man_left = 1'b1;
          end
          default: begin
            man_turn = turn_r;
          end
        endcase
      end
    end else if (in_op_r == OP_PULSE &&
                 (st_r.phase == PH_BACK || st_r.phase == PH_TURN)) begin
      st_nxt.pulse_cnt = pulse_inc;
      if (pulse_inc >= st_r.target) begin
        if (st_r.phase == PH_BACK) begin
          st_nxt.motor = M_STOP;
          start_turn   = 1'b1;
        end else begin
          end_turn = 1'b1;
        end
      end
    end else if (in_op_r == OP_ECHO && st_r.phase == PH_ECHO) begin
      if (obstacle) begin
        st_nxt.motor = M_STOP;
        st_nxt.servo = 1'b1;
        st_nxt.phase = PH_COLOUR;
      end else begin
        finish = 1'b1;
      end
    end else if (in_op_r == OP_COLOUR && st_r.phase == PH_COLOUR) begin
      class_nxt    = colour;
      cvalid_nxt   = 1'b1;
      st_nxt.servo = 1'b0;
      do_man       = 1'b1;
      man_left     = 1'b1;
      man_obst     = 1'b1;
    end

    // launch the reverse phase
    if (do_man) begin
      st_nxt.turn_left   = man_left;
      st_nxt.turn_target = man_turn;
      st_nxt.after_obst  = man_obst;
      st_nxt.pulse_cnt   = '0;
      st_nxt.target      = man_back;
      st_nxt.motor       = M_REV;
      st_nxt.phase       = PH_BACK;
      if (man_back == '0) begin
        st_nxt.motor = M_STOP;
        start_turn   = 1'b1;
      end
    end

    // launch the spin phase
    if (start_turn) begin
      st_nxt.pulse_cnt = '0;
      st_nxt.target    = st_nxt.turn_target;
      st_nxt.motor     = st_nxt.turn_left ? M_LEFT : M_RIGHT;
      st_nxt.phase     = PH_TURN;
      if (st_nxt.turn_target == '0) begin
        end_turn = 1'b1;
      end
    end

    // spin over: go on to the echo, or close the pass after an obstacle
    if (end_turn) begin
      st_nxt.motor = M_STOP;
      if (st_nxt.after_obst) begin
        finish = 1'b1;
      end else begin
        st_nxt.phase = PH_ECHO;
      end
    end

    if (finish) begin
      st_nxt.phase      = PH_LINE;
      st_nxt.motor      = M_FWD;
      st_nxt.servo      = 1'b0;
      st_nxt.after_obst = 1'b0;
      st_nxt.pulse_cnt  = '0;
      st_nxt.target     = '0;
    end
    done_nxt = finish;
  end

  always_comb begin
    unique case (st_nxt.phase)
      PH_BACK, PH_TURN: await_nxt = OP_PULSE;
      PH_ECHO:          await_nxt = OP_ECHO;
      PH_COLOUR:        await_nxt = OP_COLOUR;
      default:          await_nxt = OP_LINE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State and result registers: advance together, so the next item sees the
  // state that this one leaves
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase       <= PH_LINE;
      st_r.pulse_cnt   <= '0;
      st_r.target      <= '0;
      st_r.turn_left   <= 1'b0;
      st_r.turn_target <= '0;
      st_r.after_obst  <= 1'b0;
      st_r.motor       <= M_STOP;
      st_r.servo       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (advance) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r   <= {await_nxt, class_nxt, st_nxt.servo, st_nxt.motor};
      out_cvalid_r <= cvalid_nxt;
      out_done_r   <= done_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_cvalid_r;
  assign out_tlast  = out_done_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_done_forward: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |->
      out_data_r[MOTOR_W-1:0] == M_FWD &&
      out_data_r[OUT_DATA_W-1 -: OP_W] == OP_LINE && !out_data_r[MOTOR_W])
    else $error("pass end without forward motion and a line wait");

  a_class_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_cvalid_r |-> out_data_r[MOTOR_W+1 +: CLASS_W] == CLR_NONE)
    else $error("colour class shown without colour_valid");

  a_pulse_below: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_BACK || st_r.phase == PH_TURN |-> st_r.pulse_cnt < st_r.target)
    else $error("maneuver phase outlived its pulse target");

  a_servo_colour: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.servo |-> st_r.phase == PH_COLOUR)
    else $error("servo raised outside the colour wait");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_tready)
    else $error("input stage empty but not ready");

endmodule
